@@ src/crc8_frame_checker_unit_assert.svh @@
// assertion macros used by the rtl file crc8_frame_checker_unit.sv
`ifndef CRC8_FRAME_CHECKER_UNIT_ASSERT_SVH
`define CRC8_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk and off while rst_n is low
`define CRC8FC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CRC8FC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/crc8fc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package crc8fc_pkg;

    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CHAR_L     = 8'h4C;
    localparam logic [7:0] CHAR_M     = 8'h4D;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_R     = 8'h52;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] IMU_CMD    = 8'd11;
    localparam logic [8:0] IMU_OFFSET = 9'd180;
    localparam logic [7:0] MIN_COUNT  = 8'd3;
    localparam logic [7:0] COUNT_MAX  = 8'd255;
    localparam int         HEAD_DEPTH = 7;

    typedef enum logic [1:0] {
        ST_INVALID = 2'd0,
        ST_REPLY   = 2'd1,
        ST_IMU     = 2'd2,
        ST_VALID   = 2'd3
    } frame_status_t;

    typedef struct packed {
        frame_status_t      status;
        logic signed [8:0]  imu_first;
        logic signed [8:0]  imu_second;
        logic signed [8:0]  imu_third;
        logic signed [7:0]  imu_fourth;
    } result_t;

    // crc-8, msb first, one byte per call
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/crc8_frame_checker_unit.sv @@
// channel  dir  tdata                                     tuser              tlast
// s        in   [7:0] rx_byte                             -                  frame_end
// m        out  [8:0] imu_first [17:9] imu_second         [1:0] frame_status -
//               [26:18] imu_third [34:27] imu_fourth
//
// one byte is taken per cycle while s_tready is high; frame state updates in the same cycle
// the final byte of a frame yields one result, registered in the output slot, or in the skid slot while m stalls
// an output register plus a skid register keep input flowing while m stalls
// s_tready drops only when both output slots hold results
// rst_n clears frame state and both output slots; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
`include "crc8_frame_checker_unit_assert.svh"

module crc8_frame_checker_unit #(
    parameter int MAX_FRAME = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // imu_first, imu_second, imu_third, imu_fourth, zero pad
    output logic [1:0]       m_tuser    // [1:0] frame_status
);

    localparam logic [7:0] MAX_FRAME_B = 8'(MAX_FRAME);

    logic [7:0] running_crc_reg, running_crc_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic [7:0] second_previous_byte_reg, second_previous_byte_next;
    logic [7:0] head_bytes_reg [crc8fc_pkg::HEAD_DEPTH];
    logic [7:0] head_bytes_next [crc8fc_pkg::HEAD_DEPTH];
    logic       overflow_reg, overflow_next;

    logic                  out_valid_reg, skid_valid_reg;
    crc8fc_pkg::result_t   out_data_reg, skid_data_reg;
    crc8fc_pkg::result_t   result;

    logic s_accept;
    logic produce;
    logic frame_ok;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign produce  = s_accept && s_tlast;

    // head bytes with this transaction's byte merged in
    always_comb
    begin
        for (int i = 0; i < crc8fc_pkg::HEAD_DEPTH; i++)
        begin
            if (byte_count_reg == 8'(i))
                head_bytes_next[i] = s_tdata;
            else
                head_bytes_next[i] = head_bytes_reg[i];
        end
    end

    always_comb
    begin
        overflow_next = overflow_reg || (byte_count_reg >= MAX_FRAME_B);
        running_crc_next = crc8fc_pkg::crc8_update(running_crc_reg, s_tdata);
        second_previous_byte_next = previous_byte_reg;
        previous_byte_next = s_tdata;
        if (byte_count_reg != crc8fc_pkg::COUNT_MAX)
            byte_count_next = byte_count_reg + 8'd1;
        else
            byte_count_next = byte_count_reg;
    end

    always_comb
    begin
        frame_ok = (byte_count_reg >= crc8fc_pkg::MIN_COUNT) && !overflow_next
                   && (head_bytes_next[0] == crc8fc_pkg::CHAR_L)
                   && (second_previous_byte_reg == crc8fc_pkg::CHAR_M)
                   && (previous_byte_reg == crc8fc_pkg::CHAR_H)
                   && (running_crc_reg == s_tdata);
        result = '0;
        if (!frame_ok)
            result.status = crc8fc_pkg::ST_INVALID;
        else if (head_bytes_next[1] == crc8fc_pkg::CHAR_R)
            result.status = crc8fc_pkg::ST_REPLY;
        else if ((head_bytes_next[1] == crc8fc_pkg::CHAR_D)
                 && (head_bytes_next[2] == crc8fc_pkg::IMU_CMD))
        begin
            result.status     = crc8fc_pkg::ST_IMU;
            result.imu_first  = {1'b0, head_bytes_next[3]} - crc8fc_pkg::IMU_OFFSET;
            result.imu_second = {1'b0, head_bytes_next[4]} - crc8fc_pkg::IMU_OFFSET;
            result.imu_third  = {1'b0, head_bytes_next[5]} - crc8fc_pkg::IMU_OFFSET;
            result.imu_fourth = head_bytes_next[6];
        end
        else
            result.status = crc8fc_pkg::ST_VALID;
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg          <= '0;
            byte_count_reg           <= '0;
            previous_byte_reg        <= '0;
            second_previous_byte_reg <= '0;
            overflow_reg             <= 1'b0;
            for (int i = 0; i < crc8fc_pkg::HEAD_DEPTH; i++)
                head_bytes_reg[i] <= '0;
        end
        else if (s_accept)
        begin
            if (s_tlast)
            begin
                running_crc_reg          <= '0;
                byte_count_reg           <= '0;
                previous_byte_reg        <= '0;
                second_previous_byte_reg <= '0;
                overflow_reg             <= 1'b0;
                for (int i = 0; i < crc8fc_pkg::HEAD_DEPTH; i++)
                    head_bytes_reg[i] <= '0;
            end
            else
            begin
                running_crc_reg          <= running_crc_next;
                byte_count_reg           <= byte_count_next;
                previous_byte_reg        <= previous_byte_next;
                second_previous_byte_reg <= second_previous_byte_next;
                overflow_reg             <= overflow_next;
                for (int i = 0; i < crc8fc_pkg::HEAD_DEPTH; i++)
                    head_bytes_reg[i] <= head_bytes_next[i];
            end
        end
    end

    // output register with skid slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !m_tready)
        begin
            if (produce)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= produce;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !m_tready)
        begin
            if (produce)
                skid_data_reg <= result;
        end
        else if (skid_valid_reg)
            out_data_reg <= skid_data_reg;
        else if (produce)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.status;
    assign m_tdata  = {5'b0, out_data_reg.imu_fourth, out_data_reg.imu_third,
                       out_data_reg.imu_second, out_data_reg.imu_first};

    `CRC8FC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid slot full while output slot empty")
    `CRC8FC_ASSERT_NEXT(a_stall_fills_skid, produce && out_valid_reg && !m_tready,
        skid_valid_reg, "result lost while output stalled")
    `CRC8FC_ASSERT_NEXT(a_frame_state_cleared, produce,
        byte_count_reg == 8'd0 && running_crc_reg == 8'd0 && !overflow_reg,
        "frame state not cleared after final byte")
    `CRC8FC_ASSERT_NOW(a_imu_zero_otherwise,
        m_tvalid && m_tuser != crc8fc_pkg::ST_IMU, m_tdata == 40'd0,
        "imu fields nonzero outside imu status")
    `CRC8FC_ASSERT_NOW(a_overflow_count, overflow_reg, byte_count_reg >= MAX_FRAME_B,
        "overflow flag set on a short count")

endmodule

`default_nettype wire

@@ bench/tb_crc8_frame_checker_unit.sv @@
`timescale 1ns / 1ps

module tb_crc8_frame_checker_unit;
    import crc8fc_pkg::*;

    localparam int MAX_FRAME   = 64;
    localparam int TOTAL_BYTES = 1450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 8;

    typedef enum int {
        FK_REPLY,
        FK_IMU,
        FK_OTHER
    } frame_kind_t;

    // tracks frame state and holds the results the block still owes
    class frame_scoreboard;
        logic [7:0] crc;
        logic [7:0] count;
        logic [7:0] prev1;
        logic [7:0] prev2;
        logic [7:0] head [HEAD_DEPTH];
        bit         ovf;
        result_t    expected_q[$];
        int         errors;
        int         status_seen [4];

        function new();
            clear();
            errors = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void clear();
            crc   = '0;
            count = '0;
            prev1 = '0;
            prev2 = '0;
            ovf   = 1'b0;
            foreach (head[i])
                head[i] = '0;
        endfunction

        // bitwise form: feedback is msb of crc xor the incoming data bit
        static function logic [7:0] crc_next(logic [7:0] c, logic [7:0] b);
            logic fb;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0};
                if (fb)
                    c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            result_t r;
            if (count < HEAD_DEPTH)
                head[count] = b;
            if (count >= MAX_FRAME)
                ovf = 1'b1;
            if (!last)
            begin
                crc   = crc_next(crc, b);
                prev2 = prev1;
                prev1 = b;
                if (count != COUNT_MAX)
                    count++;
                return;
            end
            r = '0;
            if (count < MIN_COUNT || ovf || head[0] != CHAR_L || prev2 != CHAR_M
                || prev1 != CHAR_H || crc != b)
                r.status = ST_INVALID;
            else if (head[1] == CHAR_R)
                r.status = ST_REPLY;
            else if (head[1] == CHAR_D && head[2] == IMU_CMD)
            begin
                r.status     = ST_IMU;
                r.imu_first  = {1'b0, head[3]} - IMU_OFFSET;
                r.imu_second = {1'b0, head[4]} - IMU_OFFSET;
                r.imu_third  = {1'b0, head[5]} - IMU_OFFSET;
                r.imu_fourth = head[6];
            end
            else
                r.status = ST_VALID;
            expected_q.push_back(r);
            status_seen[r.status]++;
            clear();
        endfunction

        function void check_result(logic [39:0] data, logic [1:0] user);
            result_t exp_r;
            logic signed [8:0] got1, got2, got3;
            logic signed [7:0] got4;
            if (expected_q.size() == 0)
            begin
                $error("result with no frame pending: status %0d", user);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            got1  = data[8:0];
            got2  = data[17:9];
            got3  = data[26:18];
            got4  = data[34:27];
            if (user != exp_r.status)
            begin
                $error("frame_status expected %0d got %0d", exp_r.status, user);
                errors++;
            end
            if (got1 != exp_r.imu_first)
            begin
                $error("imu_first expected %0d got %0d", exp_r.imu_first, got1);
                errors++;
            end
            if (got2 != exp_r.imu_second)
            begin
                $error("imu_second expected %0d got %0d", exp_r.imu_second, got2);
                errors++;
            end
            if (got3 != exp_r.imu_third)
            begin
                $error("imu_third expected %0d got %0d", exp_r.imu_third, got3);
                errors++;
            end
            if (got4 != exp_r.imu_fourth)
            begin
                $error("imu_fourth expected %0d got %0d", exp_r.imu_fourth, got4);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    frame_scoreboard sb = new();
    bit          idle_en = 1'b1;
    int          cycle_count = 0;
    int          bytes_sent = 0;
    int          frames_sent = 0;
    logic [7:0]  frame_buf[$];

    crc8_frame_checker_unit #(
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_crc8_frame_checker_unit NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
        m_tready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_en && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b, last);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
        frames_sent++;
    endtask

    // appends the checksum of the buffered bytes, spoiled if asked
    task automatic send_with_crc(input bit spoil);
        logic [7:0] c;
        c = '0;
        foreach (frame_buf[i])
            c = frame_scoreboard::crc_next(c, frame_buf[i]);
        if (spoil)
            c = c ^ 8'($urandom_range(255, 1));
        frame_buf.push_back(c);
        send_frame();
    endtask

    // L, kind byte, command byte, payload, M, H; send_with_crc appends the checksum
    task automatic build_frame(input int len, input frame_kind_t kind);
        frame_buf.delete();
        frame_buf.push_back(CHAR_L);
        for (int i = 1; i < len - 3; i++)
            frame_buf.push_back(8'($urandom_range(255)));
        if (len > 4)
        begin
            if (kind == FK_REPLY)
                frame_buf[1] = CHAR_R;
            else if (kind == FK_IMU)
                frame_buf[1] = CHAR_D;
        end
        if (len > 5 && kind == FK_IMU)
            frame_buf[2] = IMU_CMD;
        frame_buf.push_back(CHAR_M);
        frame_buf.push_back(CHAR_H);
    endtask

    task automatic send_imu(input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [7:0] d);
        frame_buf = '{CHAR_L, CHAR_D, IMU_CMD, a, b, c, d, CHAR_M, CHAR_H};
        send_with_crc(1'b0);
    endtask

    task automatic random_frame();
        int          len;
        int          pick;
        frame_kind_t kind;
        pick = $urandom_range(99);
        if (pick < 2)
            len = $urandom_range(280, 250);
        else if (pick < 15)
            len = $urandom_range(MAX_FRAME + 6, 17);
        else
            len = $urandom_range(16, 4);
        pick = $urandom_range(99);
        if (pick < 6)
        begin
            // noise: random bytes of random length
            frame_buf.delete();
            len = $urandom_range(12, 1);
            for (int i = 0; i < len; i++)
                frame_buf.push_back(8'($urandom_range(255)));
            send_frame();
            return;
        end
        kind = frame_kind_t'($urandom_range(2));
        build_frame(len, kind);
        if (pick < 16)
        begin
            // break the header or the trailer marker
            case ($urandom_range(2))
                0: frame_buf[0] ^= 8'($urandom_range(255, 1));
                1: frame_buf[len - 3] ^= 8'($urandom_range(255, 1));
                default: frame_buf[len - 2] ^= 8'($urandom_range(255, 1));
            endcase
        end
        send_with_crc(pick >= 16 && pick < 26);
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // well-formed frames of each kind
        frame_buf = '{CHAR_L, CHAR_M, CHAR_H};
        send_with_crc(1'b0);
        frame_buf = '{CHAR_L, CHAR_R, CHAR_M, CHAR_H};
        send_with_crc(1'b0);
        send_imu(8'd0, 8'd255, 8'd180, 8'h80);
        send_imu(8'd255, 8'd0, 8'd179, 8'h7F);
        // imu frame too short to reach the upper offsets
        frame_buf = '{CHAR_L, CHAR_D, IMU_CMD, CHAR_M, CHAR_H};
        send_with_crc(1'b0);
        frame_buf = '{CHAR_L, CHAR_D, 8'd12, CHAR_M, CHAR_H};
        send_with_crc(1'b0);

        // short frames
        frame_buf = '{8'hFF};
        send_frame();
        frame_buf = '{CHAR_L, 8'h00};
        send_frame();
        frame_buf = '{CHAR_M, CHAR_H};
        send_with_crc(1'b0);

        // the crc, L, M and H checks each failing on its own
        frame_buf = '{CHAR_L, CHAR_R, CHAR_M, CHAR_H};
        send_with_crc(1'b1);
        frame_buf = '{8'h4B, CHAR_R, CHAR_M, CHAR_H};
        send_with_crc(1'b0);
        frame_buf = '{CHAR_L, CHAR_R, 8'h4E, CHAR_H};
        send_with_crc(1'b0);
        frame_buf = '{CHAR_L, CHAR_R, CHAR_M, 8'h49};
        send_with_crc(1'b0);

        // length limit and count saturation
        build_frame(MAX_FRAME, FK_OTHER);
        send_with_crc(1'b0);
        build_frame(MAX_FRAME + 1, FK_REPLY);
        send_with_crc(1'b0);
        build_frame(300, FK_IMU);
        send_with_crc(1'b0);

        // hold off until the block has drained
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);

        while (bytes_sent < TOTAL_BYTES)
        begin
            idle_en = !(frames_sent >= 40 && frames_sent < 70);
            random_frame();
        end
        idle_en = 1'b1;
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("covered %0d frames, %0d bytes, with and without stalls",
                 frames_sent, bytes_sent);
        $display("results: invalid %0d, reply %0d, imu %0d, plain valid %0d",
                 sb.status_seen[ST_INVALID], sb.status_seen[ST_REPLY],
                 sb.status_seen[ST_IMU], sb.status_seen[ST_VALID]);
        if (sb.errors == 0)
            $display("tb_crc8_frame_checker_unit OK");
        else
            $display("tb_crc8_frame_checker_unit NOT OK");
        $finish;
    end

endmodule
